[rtl/pfet_pkg.sv]
// ----------------------------------------------------------------------------
// pfet_pkg
// Shared types, codes and default sizes for the page free extent table.
// ----------------------------------------------------------------------------
package pfet_pkg;

    // Default table geometry.
    localparam int SLOT_COUNT_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 16;

    // Extent lengths and reported offsets are always 16 bits wide.
    localparam int LEN_W = 16;

    // Request codes.
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    // Result codes.
    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_MERGED    = 3'd2,
        ST_NEW_SLOT  = 3'd3,
        ST_REPLACED  = 3'd4,
        ST_DROPPED   = 3'd5,
        ST_DISABLED  = 3'd6
    } t_status;

    // Request word.
    typedef struct packed {
        t_cmd             cmd;
        logic [LEN_W-1:0] req_size;
        logic [LEN_W-1:0] free_offset;
    } t_in_word;

    // Result word.
    typedef struct packed {
        t_status          status;
        logic [LEN_W-1:0] alloc_offset;
    } t_out_word;

endpackage

[rtl/pfet_cell.sv]
// ----------------------------------------------------------------------------
// pfet_cell
// One slot of the extent ring: holds a start and a length and takes its
// neighbor's slot on every shift.
// ----------------------------------------------------------------------------
module pfet_cell #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [OFFSET_BITS-1:0]        i_start,
    input  logic [pfet_pkg::LEN_W-1:0]    i_len,
    output logic [OFFSET_BITS-1:0]        o_start,
    output logic [pfet_pkg::LEN_W-1:0]    o_len
);
    import pfet_pkg::*;

    logic [OFFSET_BITS-1:0] r_start;
    logic [LEN_W-1:0]       r_len;

    // The slot is empty after reset and moves one place per shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_len   <= '0;
        end else if (i_shift) begin
            r_start <= i_start;
            r_len   <= i_len;
        end
    end

    assign o_start = r_start;
    assign o_len   = r_len;

endmodule

[rtl/pfet_ctrl.sv]
// ----------------------------------------------------------------------------
// pfet_ctrl
// Scan controller at the head of the ring: looks at one slot per cycle,
// rewrites it on its way back to the tail, and holds the result register.
// ----------------------------------------------------------------------------
module pfet_ctrl #(
    parameter int SLOT_COUNT  = 32,
    parameter int OFFSET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enabled,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pfet_pkg::t_in_word            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pfet_pkg::t_out_word           o_out_data,
    input  logic [OFFSET_BITS-1:0]        i_head_start,
    input  logic [pfet_pkg::LEN_W-1:0]    i_head_len,
    output logic [OFFSET_BITS-1:0]        o_tail_start,
    output logic [pfet_pkg::LEN_W-1:0]    o_tail_len,
    output logic                          o_shift
);
    import pfet_pkg::*;

    localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PASS1  = 4'b0010,
        S_PASS2  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                 r_state,   n_state;
    logic [CNT_W-1:0]       r_cnt,     n_cnt;
    logic                   r_done,    n_done;
    t_cmd                   r_cmd,     n_cmd;
    logic [LEN_W-1:0]       r_size,    n_size;
    logic [OFFSET_BITS-1:0] r_off,     n_off;
    logic [CNT_W-1:0]       r_min_idx, n_min_idx;
    logic [LEN_W-1:0]       r_min_len, n_min_len;
    t_status                r_status,  n_status;
    logic [LEN_W-1:0]       r_aoff,    n_aoff;
    logic                   r_out_valid;
    t_out_word              r_out_data;

    logic [31:0]            w_off32;
    logic [31:0]            w_size32;
    logic [31:0]            w_len32;
    logic [31:0]            w_start32;
    logic [OFFSET_BITS-1:0] w_size_ob;
    logic [OFFSET_BITS-1:0] w_len_ob;
    logic [OFFSET_BITS-1:0] w_end;
    logic [OFFSET_BITS-1:0] w_head_end;
    logic [LEN_W:0]         w_sum;
    logic [LEN_W-1:0]       w_sat_len;
    logic                   w_last;
    logic                   w_out_free;

    // Width adaptation between 16-bit fields and the offset width.
    always_comb begin
        w_off32                    = {16'b0, i_in_data.free_offset};
        w_size32                   = {16'b0, r_size};
        w_len32                    = {16'b0, i_head_len};
        w_start32                  = '0;
        w_start32[OFFSET_BITS-1:0] = i_head_start;
    end

    assign w_size_ob  = w_size32[OFFSET_BITS-1:0];
    assign w_len_ob   = w_len32[OFFSET_BITS-1:0];
    assign w_end      = r_off + w_size_ob;
    assign w_head_end = i_head_start + w_len_ob;

    // Merged length saturates at the largest 16-bit value.
    assign w_sum     = {1'b0, i_head_len} + {1'b0, r_size};
    assign w_sat_len = w_sum[LEN_W] ? {LEN_W{1'b1}} : w_sum[LEN_W-1:0];

    assign w_last     = (r_cnt == CNT_LAST);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Sequencer and head-slot rewrite.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_done       = r_done;
        n_cmd        = r_cmd;
        n_size       = r_size;
        n_off        = r_off;
        n_min_idx    = r_min_idx;
        n_min_len    = r_min_len;
        n_status     = r_status;
        n_aoff       = r_aoff;
        o_tail_start = i_head_start;
        o_tail_len   = i_head_len;
        o_shift      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_data.cmd;
                    n_size   = i_in_data.req_size;
                    n_off    = w_off32[OFFSET_BITS-1:0];
                    n_cnt    = '0;
                    n_done   = 1'b0;
                    n_aoff   = '0;
                    n_status = ST_NO_FIT;
                    if (!i_enabled) begin
                        n_status = ST_DISABLED;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_PASS1;
                    end
                end
            end

            // First lap: first-fit allocate, or merge search for a free.
            S_PASS1: begin
                o_shift = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (!r_done) begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (i_head_len == r_size) begin
                            o_tail_start = '0;
                            o_tail_len   = '0;
                            n_done       = 1'b1;
                            n_status     = ST_ALLOCATED;
                            n_aoff       = w_start32[LEN_W-1:0];
                        end else if (i_head_len > r_size) begin
                            o_tail_start = i_head_start + w_size_ob;
                            o_tail_len   = i_head_len - r_size;
                            n_done       = 1'b1;
                            n_status     = ST_ALLOCATED;
                            n_aoff       = w_start32[LEN_W-1:0];
                        end
                    end else begin
                        if (w_end == i_head_start) begin
                            o_tail_start = r_off;
                            o_tail_len   = w_sat_len;
                            n_done       = 1'b1;
                            n_status     = ST_MERGED;
                        end else if (w_head_end == r_off) begin
                            o_tail_len = w_sat_len;
                            n_done     = 1'b1;
                            n_status   = ST_MERGED;
                        end
                    end
                end
                // The first minimum is also the first empty slot if any.
                if ((r_cnt == '0) || (i_head_len < r_min_len)) begin
                    n_min_idx = r_cnt;
                    n_min_len = i_head_len;
                end
                if (w_last) begin
                    n_cnt = '0;
                    if ((r_cmd == CMD_ALLOC) || n_done) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_PASS2;
                    end
                end
            end

            // Second lap: fill the empty slot, replace the smallest one, or drop the extent.
            S_PASS2: begin
                o_shift = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == r_min_idx) begin
                    if (r_min_len == '0) begin
                        o_tail_start = r_off;
                        o_tail_len   = r_size;
                        n_status     = ST_NEW_SLOT;
                    end else if (r_size > r_min_len) begin
                        o_tail_start = r_off;
                        o_tail_len   = r_size;
                        n_status     = ST_REPLACED;
                    end else begin
                        n_status = ST_DROPPED;
                    end
                end
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Request and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_size    <= n_size;
        r_off     <= n_off;
        r_min_idx <= n_min_idx;
        r_min_len <= n_min_len;
        r_status  <= n_status;
        r_aoff    <= n_aoff;
    end

    // Result register: loads when the scan is finished and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && w_out_free) begin
            r_out_data.status       <= r_status;
            r_out_data.alloc_offset <= r_aoff;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/page_free_extent_table.sv]
// ----------------------------------------------------------------------------
// page_free_extent_table
// First-fit free extent table built as a rotating ring of slot cells with
// a scan controller at its head.
// ----------------------------------------------------------------------------
// An allocate, or a free that merges, raises its result after one full lap of the
// ring; a free that needs the second lap takes two laps, and a disabled request
// skips the scan. One request word is in flight at a time: a new word is taken
// only once the previous result has been loaded, which waits for the result side;
// the ring rotates one slot per cycle past the head while a scan is running.
// Reset (synchronous, active low) empties every slot at once and enables
// the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_free_extent_table #(
    parameter int SLOT_COUNT  = pfet_pkg::SLOT_COUNT_DEF,
    parameter int OFFSET_BITS = pfet_pkg::OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pfet_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pfet_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);
    import pfet_pkg::*;

    logic                   r_enabled;
    logic [OFFSET_BITS-1:0] w_start [SLOT_COUNT+1];
    logic [LEN_W-1:0]       w_len   [SLOT_COUNT+1];
    logic                   w_shift;

    // Enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    // Slot ring: cell k takes cell k+1, the last cell takes the head rewrite.
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        pfet_cell #(
            .OFFSET_BITS(OFFSET_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_shift),
            .i_start(w_start[k+1]),
            .i_len  (w_len[k+1]),
            .o_start(w_start[k]),
            .o_len  (w_len[k])
        );
    end

    // Head controller.
    pfet_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enabled   (r_enabled),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head_start(w_start[0]),
        .i_head_len  (w_len[0]),
        .o_tail_start(w_start[SLOT_COUNT]),
        .o_tail_len  (w_len[SLOT_COUNT]),
        .o_shift     (w_shift)
    );

endmodule

[test/tb_page_free_extent_table.sv]
// ----------------------------------------------------------------------------
// tb_page_free_extent_table
// Self-checking bench for the first-fit free extent table. A scoreboard
// keeps its own copy of the slot table, predicts one result word per
// accepted request word, and compares each accepted result field by field.
// Stimulus is a short directed run followed by random allocate and free
// traffic, with random idling on both channels and enable/disable phases.
// ----------------------------------------------------------------------------
module tb_page_free_extent_table;

    timeunit 1ns;
    timeprecision 1ps;

    import pfet_pkg::*;

    localparam int SLOTS      = SLOT_COUNT_DEF;
    localparam int HOLD_LONG  = 600;
    localparam int SETTLE_CYC = 70;
    localparam int RAND_ITEMS = 1600;

    // ------------------------------------------------------------------------
    // Scoreboard: slot table copy, enable flag and the queue of due results.
    // ------------------------------------------------------------------------
    class extent_scoreboard;
        logic [LEN_W-1:0] start_q [SLOTS];
        logic [LEN_W-1:0] length_q[SLOTS];
        bit               table_on;
        t_out_word        due_results[$];
        int               mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                start_q[i]  = '0;
                length_q[i] = '0;
            end
            table_on   = 1'b1;
            mismatches = 0;
        endfunction

        function void set_table_on(bit v);
            table_on = v;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Merged lengths saturate at the largest 16-bit value.
        function logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
            logic [LEN_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(t_in_word w);
            t_out_word        r;
            int               smallest;
            bit               done;
            logic [LEN_W-1:0] off;
            logic [LEN_W-1:0] fin;
            r.status       = ST_ALLOCATED;
            r.alloc_offset = '0;
            done           = 1'b0;
            smallest       = 0;
            off            = w.free_offset;
            fin            = w.free_offset + w.req_size;
            if (!table_on) begin
                r.status = ST_DISABLED;
            end else if (w.cmd == CMD_ALLOC) begin
                // First fit: an exact length empties the slot, a longer one shrinks it.
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (length_q[i] == w.req_size) begin
                        r.alloc_offset = start_q[i];
                        start_q[i]     = '0;
                        length_q[i]    = '0;
                        done           = 1'b1;
                    end else if (length_q[i] > w.req_size) begin
                        r.alloc_offset = start_q[i];
                        start_q[i]     = start_q[i] + w.req_size;
                        length_q[i]    = length_q[i] - w.req_size;
                        done           = 1'b1;
                    end
                end
                if (!done) begin
                    r.status = ST_NO_FIT;
                end
            end else begin
                // Merge pass: the first slot the extent precedes or follows.
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (fin == start_q[i]) begin
                        start_q[i]  = off;
                        length_q[i] = sat_len(length_q[i], w.req_size);
                        r.status    = ST_MERGED;
                        done        = 1'b1;
                    end else if (LEN_W'(start_q[i] + length_q[i]) == off) begin
                        length_q[i] = sat_len(length_q[i], w.req_size);
                        r.status    = ST_MERGED;
                        done        = 1'b1;
                    end
                end
                // Placement pass: first empty slot, tracking the smallest on the way.
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (length_q[i] == '0) begin
                        start_q[i]  = off;
                        length_q[i] = w.req_size;
                        r.status    = ST_NEW_SLOT;
                        done        = 1'b1;
                    end else if (length_q[i] < length_q[smallest]) begin
                        smallest = i;
                    end
                end
                if (!done) begin
                    if (w.req_size > length_q[smallest]) begin
                        start_q[smallest]  = off;
                        length_q[smallest] = w.req_size;
                        r.status           = ST_REPLACED;
                    end else begin
                        r.status = ST_DROPPED;
                    end
                end
            end
            due_results = {due_results, r};
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (due_results.size() == 0) begin
                $error("result word with nothing expected: status %0d alloc_offset 0x%04h",
                       got.status, got.alloc_offset);
                mismatches++;
                return;
            end
            exp_w = due_results.pop_front();
            if (got.status !== exp_w.status) begin
                $error("status: expected %0d, actual %0d", exp_w.status, got.status);
                mismatches++;
            end
            if (got.alloc_offset !== exp_w.alloc_offset) begin
                $error("alloc_offset: expected 0x%04h, actual 0x%04h",
                       exp_w.alloc_offset, got.alloc_offset);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_data;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    extent_scoreboard sb;

    bit               no_idle;
    bit               hold_off_req;
    logic [LEN_W-1:0] run_cursor;
    logic [LEN_W-1:0] run_low;
    logic [LEN_W-1:0] freed_sizes[$];

    page_free_extent_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock, 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Idle cycles before a word, shared by both channels.
    function int draw_idle();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    function t_in_word mk(t_cmd cmd, logic [LEN_W-1:0] size, logic [LEN_W-1:0] off);
        t_in_word w;
        w.cmd         = cmd;
        w.req_size    = size;
        w.free_offset = off;
        return w;
    endfunction

    // Random request: mostly runs of adjacent frees, scattered frees and
    // fitting allocates, with some fully random noise.
    function t_in_word make_request();
        t_in_word         w;
        int               pick;
        logic [LEN_W-1:0] size;
        pick = $urandom_range(0, 99);
        w    = mk(CMD_ALLOC, '0, LEN_W'($urandom()));
        if (pick < 22) begin
            // Exact fit against a recently freed length.
            if (freed_sizes.size() > 0) begin
                w.req_size = freed_sizes[$urandom_range(0, freed_sizes.size() - 1)];
            end else begin
                w.req_size = LEN_W'($urandom_range(1, 64));
            end
        end else if (pick < 36) begin
            w.req_size = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'($urandom_range(1, 48));
        end else if (pick < 84) begin
            w.cmd = CMD_FREE;
            if (pick < 56) begin
                size = LEN_W'($urandom_range(1, 200));
            end else if (pick < 76) begin
                size = LEN_W'($urandom_range(1, 4095));
            end else begin
                size = LEN_W'($urandom_range(16'hF000, 16'hFFFF));
            end
            if (pick >= 56 && pick < 76) begin
                w.free_offset = LEN_W'($urandom());
            end else if (pick < 56 && $urandom_range(0, 3) == 0) begin
                // Extent just in front of the run.
                run_low       = run_low - size;
                w.free_offset = run_low;
            end else begin
                w.free_offset = run_cursor;
                run_cursor    = run_cursor + size;
            end
            if ($urandom_range(0, 15) == 0) begin
                run_cursor = LEN_W'($urandom());
                run_low    = run_cursor;
            end
            w.req_size  = size;
            freed_sizes = {freed_sizes, size};
            if (freed_sizes.size() > 16) begin
                void'(freed_sizes.pop_front());
            end
        end else begin
            w.cmd         = t_cmd'($urandom_range(0, 1));
            w.req_size    = LEN_W'($urandom());
            w.free_offset = LEN_W'($urandom());
        end
        return w;
    endfunction

    // Offer one request word and wait until it is taken.
    task automatic send_request(t_in_word w);
        int gap;
        gap = draw_idle();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every expected result word has come.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // Write the enable register once the block is idle.
    task automatic write_enable(bit v);
        settle();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Result channel: random stall per word, plus one long hold-off on request.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_LONG) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = draw_idle();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Monitor: check results, predict accepted requests, track register writes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in_data);
            end
            if (i_cfg_we) begin
                sb.set_table_on(i_cfg_wdata);
            end
        end
    end

    // Main sequence.
    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        run_cursor   = 16'h4000;
        run_low      = 16'h4000;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_enable(1'b1);

        // Directed: zero-size fit, merges on both sides, merge into an empty
        // slot, wrapping starts, saturated length and the field extremes.
        send_request(mk(CMD_ALLOC, 16'h0000, 16'hFFFF));
        send_request(mk(CMD_ALLOC, 16'h0005, 16'h0000));
        send_request(mk(CMD_FREE,  16'h0010, 16'h0100));
        send_request(mk(CMD_FREE,  16'h0010, 16'h0110));
        send_request(mk(CMD_FREE,  16'h0010, 16'h00F0));
        send_request(mk(CMD_ALLOC, 16'h0030, 16'h0000));
        send_request(mk(CMD_FREE,  16'h0008, 16'h0000));
        send_request(mk(CMD_FREE,  16'h0008, 16'hFFF8));
        send_request(mk(CMD_ALLOC, 16'h0004, 16'hFFFF));
        send_request(mk(CMD_FREE,  16'hFFFF, 16'h1000));
        send_request(mk(CMD_FREE,  16'h0020, 16'h0FFF));
        send_request(mk(CMD_ALLOC, 16'hFFFF, 16'h0000));
        send_request(mk(CMD_ALLOC, 16'hFFFF, 16'hFFFF));
        send_request(mk(CMD_FREE,  16'h0000, 16'hFFFF));
        send_request(mk(CMD_FREE,  16'hFFFF, 16'h0000));
        send_request(mk(CMD_ALLOC, 16'h0001, 16'h0000));
        send_request(mk(CMD_FREE,  16'h0001, 16'h8000));
        send_request(mk(CMD_ALLOC, 16'h0000, 16'h0000));
        send_request(mk(CMD_ALLOC, 16'h7FFF, 16'h0000));

        // Disabled table: everything reports disabled.
        write_enable(1'b0);
        for (int n = 0; n < 30; n++) begin
            send_request(make_request());
        end
        write_enable(1'b1);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == 400) begin
                settle();
            end
            if (n == 700) begin
                hold_off_req = 1'b1;
            end
            if (n == 1100) begin
                write_enable(1'b0);
                for (int k = 0; k < 25; k++) begin
                    send_request(make_request());
                end
                write_enable(1'b1);
            end
            send_request(make_request());
        end

        settle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #30000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
